>>> hdl/sbsm_pkg.sv
// Shared types and constants of the serial bank switch mapper.
package sbsm_pkg;

    // request kinds
    localparam logic [1:0] REQ_CPU_RD = 2'd0;
    localparam logic [1:0] REQ_CPU_WR = 2'd1;
    localparam logic [1:0] REQ_PPU_RD = 2'd2;
    localparam logic [1:0] REQ_PPU_WR = 2'd3;

    // target memories
    localparam logic [2:0] TGT_NONE = 3'd0;
    localparam logic [2:0] TGT_WRAM = 3'd1;
    localparam logic [2:0] TGT_PRG  = 3'd2;
    localparam logic [2:0] TGT_VRAM = 3'd3;
    localparam logic [2:0] TGT_CHR  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_PRG_LG  = 2'd0;
    localparam logic [1:0] CFG_CHR_LG  = 2'd1;
    localparam logic [1:0] CFG_MIRROR  = 2'd2;

    // loader destinations, address bits 14:13
    localparam logic [1:0] SEL_CONTROL = 2'd0;
    localparam logic [1:0] SEL_CHR_LO  = 2'd1;
    localparam logic [1:0] SEL_CHR_HI  = 2'd2;
    localparam logic [1:0] SEL_PRG     = 2'd3;

    // mirroring modes
    localparam logic [2:0] MIR_PAGE0 = 3'd0;
    localparam logic [2:0] MIR_PAGE1 = 3'd1;
    localparam logic [2:0] MIR_VERT  = 3'd2;
    localparam logic [2:0] MIR_HORIZ = 3'd3;

    // program modes, control bits 3:2
    localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

    localparam logic [4:0] C_CTRL_RESET   = 5'h0C;
    localparam logic [4:0] C_CTRL_MODE3   = 5'h0C;
    localparam logic [2:0] C_LG_RESET     = 3'd1;
    localparam logic [2:0] C_LG_MAX       = 3'd5;
    localparam logic [2:0] C_CHR_LG_MIN   = 3'd1;
    localparam logic [2:0] C_LOAD_LAST    = 3'd5;
    localparam int         C_MAX_PRG_BANKS = 32;
    localparam int         C_PRG_LG_LIMIT  = $clog2(C_MAX_PRG_BANKS + 1) - 1;

    typedef struct packed {
        logic [4:0] ctrl;
        logic [4:0] chr_lo;
        logic [4:0] chr_hi;
        logic [4:0] prg_bank;
        logic [2:0] mirror;
        logic [2:0] prg_lg;
        logic [2:0] chr_lg;
    } t_map_state;

    typedef struct packed {
        logic [2:0]  target;
        logic [18:0] addr;
        logic        wr;
        logic [7:0]  data;
    } t_result;

endpackage

>>> hdl/serial_bank_switch_mapper.sv
// Top level of the serial bank switch mapper: input register, translation, result register.
//
// channel  | direction | tvalid/tready         | payload
// s        | in        | i_s_tvalid/o_s_tready | tuser req_type, tdata address+data
// m        | out       | o_m_tvalid/i_m_tready | tuser target+is_write, tdata address+data
// cfg      | in        | i_cfg_we              | i_cfg_index, i_cfg_wdata
//
// One word per cycle unless the output stalls.
// The loader registers update as a word moves into the result register, so
// accesses see the state left by all earlier words.
// A stalled output holds the result register and then the input register.
// Synchronous active-low reset empties both registers and loads reset state.
module serial_bank_switch_mapper
    import sbsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // bus_address[15:0], write_value[23:16]
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // mem_address[18:0], write_data[26:19], zero
    output logic [3:0]  o_m_tuser,   // target[2:0], is_write[3]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_wdata
);

    logic        r_in_valid;
    logic [1:0]  r_in_type;
    logic [15:0] r_in_addr;
    logic [7:0]  r_in_data;
    logic        r_out_valid;
    t_result     r_out;
    t_result     result;
    t_map_state  map_state;
    logic        out_free;
    logic        move;

    assign out_free   = !r_out_valid || i_m_tready;
    assign move       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    sbsm_loader u_loader (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (move),
        .i_req_type  (r_in_type),
        .i_addr      (r_in_addr),
        .i_data      (r_in_data),
        .o_state     (map_state)
    );

    sbsm_xlate u_xlate (
        .i_state    (map_state),
        .i_req_type (r_in_type),
        .i_addr     (r_in_addr),
        .i_data     (r_in_data),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready)
                r_in_valid <= i_s_tvalid;
            if (out_free)
                r_out_valid <= r_in_valid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_type <= i_s_tuser;
            r_in_addr <= i_s_tdata[15:0];
            r_in_data <= i_s_tdata[23:16];
        end
        if (move)
            r_out <= result;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out.data, r_out.addr};
    assign o_m_tuser  = {r_out.wr, r_out.target};

`ifndef SYNTHESIS
    a_none_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2:0] == TGT_NONE |-> o_m_tdata == 32'd0)
        else $error("no-target result carries data");

    a_read_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[3] |-> o_m_tdata[26:19] == 8'd0)
        else $error("read result carries write data");

    a_wram_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2:0] == TGT_WRAM |-> o_m_tdata[18:13] == 6'd0)
        else $error("work RAM address out of range");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !move |=> r_in_valid)
        else $error("input word dropped while stalled");
`endif

endmodule

>>> hdl/sbsm_loader.sv
// Serial loader, mapper registers and configuration registers.
module sbsm_loader
    import sbsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_step,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_data,
    output t_map_state  o_state
);

    logic [4:0] r_shift, n_shift;
    logic [2:0] r_count, n_count;
    logic [4:0] r_ctrl, n_ctrl;
    logic [4:0] r_chr_lo, n_chr_lo;
    logic [4:0] r_chr_hi, n_chr_hi;
    logic [4:0] r_prg_bank, n_prg_bank;
    logic [2:0] r_mirror, n_mirror;
    logic [2:0] r_prg_lg, n_prg_lg;
    logic [2:0] r_chr_lg, n_chr_lg;
    logic [4:0] shifted;
    logic [2:0] count_inc;

    assign shifted   = {i_data[0], r_shift[4:1]};
    assign count_inc = r_count + 3'd1;

    always_comb begin
        n_shift    = r_shift;
        n_count    = r_count;
        n_ctrl     = r_ctrl;
        n_chr_lo   = r_chr_lo;
        n_chr_hi   = r_chr_hi;
        n_prg_bank = r_prg_bank;
        n_mirror   = r_mirror;
        n_prg_lg   = r_prg_lg;
        n_chr_lg   = r_chr_lg;
        if (i_step && i_req_type == REQ_CPU_WR && i_addr[15]) begin
            if (i_data[7]) begin
                n_shift  = '0;
                n_count  = '0;
                n_ctrl   = r_ctrl | C_CTRL_MODE3;
                n_mirror = {1'b0, r_ctrl[1:0]};
            end else if (count_inc >= C_LOAD_LAST) begin
                n_shift = '0;
                n_count = '0;
                case (i_addr[14:13])
                    SEL_CONTROL: begin
                        n_ctrl   = shifted;
                        n_mirror = {1'b0, shifted[1:0]};
                    end
                    SEL_CHR_LO: n_chr_lo = shifted;
                    SEL_CHR_HI: n_chr_hi = shifted;
                    default:    n_prg_bank = shifted;
                endcase
            end else begin
                n_shift = shifted;
                n_count = count_inc;
            end
        end
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRG_LG: n_prg_lg = i_cfg_wdata;
                CFG_CHR_LG: n_chr_lg = i_cfg_wdata;
                CFG_MIRROR: n_mirror = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift    <= '0;
            r_count    <= '0;
            r_ctrl     <= C_CTRL_RESET;
            r_chr_lo   <= '0;
            r_chr_hi   <= 5'd1;
            r_prg_bank <= '0;
            r_mirror   <= MIR_VERT;
            r_prg_lg   <= C_LG_RESET;
            r_chr_lg   <= C_LG_RESET;
        end else begin
            r_shift    <= n_shift;
            r_count    <= n_count;
            r_ctrl     <= n_ctrl;
            r_chr_lo   <= n_chr_lo;
            r_chr_hi   <= n_chr_hi;
            r_prg_bank <= n_prg_bank;
            r_mirror   <= n_mirror;
            r_prg_lg   <= n_prg_lg;
            r_chr_lg   <= n_chr_lg;
        end
    end

    assign o_state = '{ctrl: r_ctrl, chr_lo: r_chr_lo, chr_hi: r_chr_hi,
                       prg_bank: r_prg_bank, mirror: r_mirror,
                       prg_lg: r_prg_lg, chr_lg: r_chr_lg};

endmodule

>>> hdl/sbsm_xlate.sv
// Address translation of one bus access against the current mapper state.
module sbsm_xlate
    import sbsm_pkg::*;
(
    input  t_map_state  i_state,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_data,
    output t_result     o_result
);

    logic [2:0]  prg_lg, chr_lg;
    logic [4:0]  prg_mask, chr_mask;
    logic [4:0]  prg_bank, chr_bank;
    logic        upper;
    logic [1:0]  nt;
    logic [4:0]  pal_off;
    logic [13:0] p;
    logic        writing;

    assign writing = i_req_type[0];
    assign p       = i_addr[13:0];
    assign upper   = i_addr[14];

    always_comb begin
        prg_lg = (i_state.prg_lg > C_LG_MAX) ? C_LG_MAX : i_state.prg_lg;
        if (prg_lg > 3'(C_PRG_LG_LIMIT))
            prg_lg = 3'(C_PRG_LG_LIMIT);
        chr_lg = i_state.chr_lg;
        if (chr_lg < C_CHR_LG_MIN)
            chr_lg = C_CHR_LG_MIN;
        if (chr_lg > C_LG_MAX)
            chr_lg = C_LG_MAX;
        prg_mask = 5'((6'd1 << prg_lg) - 6'd1);
        chr_mask = 5'((6'd1 << chr_lg) - 6'd1);

        case (i_state.ctrl[3:2])
            PRG_MODE_FIX_LOW:  prg_bank = upper ? i_state.prg_bank : 5'd0;
            PRG_MODE_FIX_HIGH: prg_bank = upper ? prg_mask : i_state.prg_bank;
            default:           prg_bank = {i_state.prg_bank[4:1], upper};
        endcase
        prg_bank = prg_bank & prg_mask;

        if (i_state.ctrl[4])
            chr_bank = p[12] ? i_state.chr_hi : i_state.chr_lo;
        else
            chr_bank = {i_state.chr_lo[4:1], p[12]};
        chr_bank = chr_bank & chr_mask;

        case (i_state.mirror)
            MIR_PAGE0: nt = 2'd0;
            MIR_PAGE1: nt = 2'd1;
            MIR_VERT:  nt = {1'b0, p[10]};
            MIR_HORIZ: nt = {p[11], 1'b0};
            default:   nt = p[11:10];
        endcase

        pal_off = (p[4:0] == 5'h10) ? 5'h00 : p[4:0];

        o_result = '0;
        if (!i_req_type[1]) begin
            if (i_addr[15:13] == 3'b011) begin
                o_result.target = TGT_WRAM;
                o_result.addr   = {6'd0, i_addr[12:0]};
                o_result.wr     = writing;
            end else if (i_addr[15] && !writing) begin
                o_result.target = TGT_PRG;
                o_result.addr   = {prg_bank, i_addr[13:0]};
            end
        end else begin
            o_result.wr = writing;
            if (p[13:8] == 6'h3F) begin
                o_result.target = TGT_VRAM;
                o_result.addr   = {11'h03F, 3'd0, pal_off};
            end else if (p[13]) begin
                o_result.target = TGT_VRAM;
                o_result.addr   = {5'd0, 2'b10, nt, p[9:0]} | 19'h0;
            end else begin
                o_result.target = TGT_CHR;
                o_result.addr   = {2'd0, chr_bank, p[11:0]};
            end
        end
        o_result.data = o_result.wr ? i_data : 8'd0;
    end

endmodule
